// ----- sv/rcct_pkg.sv -----
// shared types, constants and helpers of the raycast column texturer
// used by rcct_alu and raycast_column_texturer_top; depends on nothing

package rcct_pkg;

   // screen geometry
   localparam int SCREEN_HEIGHT = 512;
   localparam int ROW_W         = 12;
   localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;

   // line height is SCREEN_HEIGHT*2^16 / dist, this many bits wide at most
   localparam int LH_W = $clog2(SCREEN_HEIGHT) + 17;
   localparam logic [LH_W-1:0] LH_SAT = LH_W'(SCREEN_HEIGHT * 65536);
   // dividend of the line height division, left aligned in 32 bits
   localparam logic [31:0] LH_DIVIDEND = 32'(SCREEN_HEIGHT * 65536) << (32 - LH_W);

   // texture size limits
   localparam int TEX_W = 13;
   localparam logic [TEX_W-1:0] TEX_MAX = TEX_W'(4096);

   // one in Q1.16
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;

   // input action codes
   localparam logic ACT_SETUP = 1'b0;
   localparam logic ACT_ROW   = 1'b1;

   // result kinds
   localparam logic [2:0] KIND_READY    = 3'd0;
   localparam logic [2:0] KIND_SKIPPED  = 3'd1;
   localparam logic [2:0] KIND_UPPER    = 3'd2;
   localparam logic [2:0] KIND_TEXTURED = 3'd3;
   localparam logic [2:0] KIND_LOWER    = 3'd4;
   localparam logic [2:0] KIND_NOTHING  = 3'd5;

   // configuration register indexes
   localparam logic [1:0] CSR_TEX_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_TEX_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_UPPER_FILL = 2'd2;
   localparam logic [1:0] CSR_LOWER_FILL = 2'd3;

   // shared shift-add / shift-subtract unit
   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   // a: multiplicand or divisor; b: multiplier or dividend, left aligned
   typedef struct packed {
      logic        start;
      alu_op_type  op;
      logic [5:0]  count;
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;

   // acc: product (low 32 bits) or remainder; quo: quotient
   typedef struct packed {
      logic        done;
      logic [31:0] acc;
      logic [31:0] quo;
   } alu_rsp_type;

   // zero acts as one, anything above 4096 as 4096
   function automatic logic [TEX_W-1:0] tex_size(input logic [TEX_W-1:0] v);
      logic [TEX_W-1:0] r;
      r = v;
      if (v == '0) r = TEX_W'(1);
      else if (v > TEX_MAX) r = TEX_MAX;
      return r;
   endfunction

endpackage

// ----- sv/raycast_column_texturer_top.sv -----
// top level of the raycast column texturer: sequencer, column state, output register
// depends on rcct_pkg and rcct_alu
//
//   channel   ports                     direction  handshake
//   request   req_* (action, ray data)  in         req_valid / req_stall
//   response  rsp_* (one per request)   out        rsp_valid / rsp_stall
//   config    csr_write/index/data      in         write on csr_write
//
// a column set-up transaction makes up to five passes through the
// shared one-bit-per-cycle multiply/divide unit (32, 13, 26, 29 and 25 steps)
// plus control states. a wall row makes a 16 step modulo and a 12 step
// multiply; fill rows and empty rows are answered without the shared unit.
// reset is synchronous and restores the register defaults; no clearing pass.
// req_stall is high while a transaction is in work, and while a result waits
// in the output register under rsp_stall.

module raycast_column_texturer_top import rcct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [10:0] req_column,
   input  logic        req_hit_side,
   input  logic        req_hit_is_door,
   input  logic [30:0] req_side_dist_x,
   input  logic [30:0] req_side_dist_y,
   input  logic [30:0] req_delta_dist_x,
   input  logic [30:0] req_delta_dist_y,
   input  logic signed [31:0] req_ray_dir_x,
   input  logic signed [31:0] req_ray_dir_y,
   input  logic [30:0] req_viewer_pos,
   input  logic [16:0] req_door_open,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_out_column,
   output logic [11:0] rsp_out_row,
   output logic [2:0]  rsp_pixel_kind,
   output logic [23:0] rsp_fill_color,
   output logic [23:0] rsp_texel_index,
   output logic        rsp_last,
   // configuration
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_PROD,
      S_TEX,
      S_HGT,
      S_WALL,
      S_STEP,
      S_POS,
      S_TY,
      S_TEXEL,
      S_OUT
   } state_type;

   localparam logic [LH_W-1:0]  HALF_L   = LH_W'(HALF_HEIGHT);
   localparam logic [LH_W:0]    HEIGHT_L = (LH_W+1)'(SCREEN_HEIGHT);
   localparam logic [ROW_W:0]   HEIGHT_R = (ROW_W+1)'(SCREEN_HEIGHT);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);

   state_type state_ff;

   // configuration registers
   logic [TEX_W-1:0] tex_width_ff;
   logic [TEX_W-1:0] tex_height_ff;
   logic [23:0]      upper_fill_ff;
   logic [23:0]      lower_fill_ff;

   // column state
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] wall_top_ff;
   logic [ROW_W-1:0] wall_bot_ff;
   logic [11:0]      tex_col_ff;
   logic [31:0]      tex_pos_ff;
   logic [31:0]      tex_step_ff;
   logic             skipped_ff;
   logic [10:0]      held_col_ff;

   // set-up working registers
   logic             door_ff;
   logic             mirror_ff;
   logic [15:0]      vpos_lo_ff;
   logic [16:0]      open_ff;
   logic [31:0]      dist_ff;
   logic [LH_W-1:0]  lh_ff;
   logic [LH_W-2:0]  term_ff;

   // pending result
   logic [2:0]       pend_kind_ff;
   logic [ROW_W-1:0] pend_row_ff;
   logic [23:0]      pend_texel_ff;
   logic             pend_last_ff;

   // output register
   logic             rsp_valid_ff;
   logic [10:0]      rsp_col_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   logic [2:0]       rsp_kind_ff;
   logic [23:0]      rsp_fill_ff;
   logic [23:0]      rsp_texel_ff;
   logic             rsp_last_ff;

   alu_req_type      alu_req_ff;
   alu_rsp_type      alu_rsp;

   rcct_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req_ff),
      .alu_rsp (alu_rsp)
   );

   logic             accept;
   logic             out_free;
   logic [TEX_W-1:0] tw;
   logic [TEX_W-1:0] th;
   logic [31:0]      dist_new;
   logic [31:0]      ray_new;
   logic             mirror_new;
   logic [16:0]      open_new;
   logic [15:0]      frac;
   logic             door_pass;
   logic [17:0]      door_sum;
   logic [15:0]      frac_tex;
   logic [11:0]      tx;
   logic [11:0]      tx_mirror;
   logic             dist_nonpos;
   logic [LH_W-1:0]  half_lh;
   logic             top_clamped;
   logic [LH_W-1:0]  top_diff;
   logic [LH_W-1:0]  term_diff;
   logic [LH_W:0]    bot_sum;
   logic [ROW_W-1:0] wall_top_new;
   logic [ROW_W-1:0] wall_bot_new;
   logic             row_past;
   logic             row_last;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // set-up arithmetic around the shared unit
   always_comb begin
      tw = tex_size(tex_width_ff);
      th = tex_size(tex_height_ff);

      if (req_hit_side) begin
         dist_new = {1'b0, req_side_dist_y} - {1'b0, req_delta_dist_y};
         ray_new  = req_ray_dir_x;
      end else begin
         dist_new = {1'b0, req_side_dist_x} - {1'b0, req_delta_dist_x};
         ray_new  = req_ray_dir_y;
      end
      mirror_new = (!req_hit_is_door && !req_hit_side && !req_ray_dir_x[31] &&
                    req_ray_dir_x != '0) || (req_hit_side && req_ray_dir_y[31]);
      open_new   = (req_door_open > ONE_Q16) ? ONE_Q16 : req_door_open;

      // hit fraction from the low word of viewer_pos*2^16 + dist*ray_dir
      frac      = alu_rsp.acc[31:16] + vpos_lo_ff;
      door_pass = door_ff && ({1'b0, frac} > open_ff);
      door_sum  = {1'b0, ONE_Q16} - {1'b0, open_ff} + {2'b00, frac};
      if (!door_ff) begin
         frac_tex = frac;
      end else if (door_sum[17:16] != 2'b00) begin
         frac_tex = 16'hFFFF;
      end else begin
         frac_tex = door_sum[15:0];
      end

      // texture column, mirrored where the wall is seen from behind
      tx          = alu_rsp.acc[27:16];
      tx_mirror   = 12'(tw - {1'b0, tx} - TEX_W'(1));
      dist_nonpos = dist_ff[31] || (dist_ff == '0);

      // wall rows from the line height
      half_lh      = {1'b0, lh_ff[LH_W-1:1]};
      top_clamped  = (half_lh >= HALF_L);
      top_diff     = HALF_L - half_lh;
      term_diff    = half_lh - HALF_L;
      bot_sum      = {1'b0, half_lh} + {1'b0, HALF_L};
      wall_top_new = top_clamped ? '0 : top_diff[ROW_W-1:0];
      wall_bot_new = (bot_sum >= HEIGHT_L) ? LAST_ROW : bot_sum[ROW_W-1:0];

      row_past = ({1'b0, row_ff} >= HEIGHT_R);
      row_last = (row_ff == LAST_ROW);
   end

   // sequencer, column state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         tex_width_ff     <= TEX_W'(64);
         tex_height_ff    <= TEX_W'(64);
         upper_fill_ff    <= '0;
         lower_fill_ff    <= '0;
         row_ff           <= '0;
         wall_top_ff      <= '0;
         wall_bot_ff      <= '0;
         tex_col_ff       <= '0;
         tex_pos_ff       <= '0;
         tex_step_ff      <= '0;
         skipped_ff       <= 1'b1;
         held_col_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
         alu_req_ff.start <= 1'b0;
      end else begin
         alu_req_ff.start <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // configuration writes
         if (csr_write) begin
            case (csr_index)
               CSR_TEX_WIDTH:  tex_width_ff  <= csr_data[TEX_W-1:0];
               CSR_TEX_HEIGHT: tex_height_ff <= csr_data[TEX_W-1:0];
               CSR_UPPER_FILL: upper_fill_ff <= csr_data;
               CSR_LOWER_FILL: lower_fill_ff <= csr_data;
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (accept && req_action == ACT_SETUP) begin
                  // column set-up: start dist * ray_dir
                  held_col_ff <= req_column;
                  row_ff      <= '0;
                  door_ff     <= req_hit_is_door;
                  mirror_ff   <= mirror_new;
                  vpos_lo_ff  <= req_viewer_pos[15:0];
                  open_ff     <= open_new;
                  dist_ff     <= dist_new;
                  alu_req_ff  <= '{start: 1'b1, op: ALU_MUL, count: 6'd32,
                                   a: dist_new, b: ray_new};
                  state_ff    <= S_PROD;
               end else if (accept) begin
                  // row transaction
                  rsp_col_ff   <= held_col_ff;
                  rsp_fill_ff  <= '0;
                  rsp_texel_ff <= '0;
                  if (skipped_ff || row_past) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff  <= KIND_NOTHING;
                     rsp_row_ff   <= '0;
                     rsp_last_ff  <= 1'b0;
                  end else begin
                     row_ff <= row_ff + ROW_W'(1);
                     if (row_last) skipped_ff <= 1'b1;
                     if (row_ff < wall_top_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_kind_ff  <= KIND_UPPER;
                        rsp_row_ff   <= row_ff;
                        rsp_fill_ff  <= upper_fill_ff;
                        rsp_last_ff  <= row_last;
                     end else if (row_ff < wall_bot_ff) begin
                        pend_row_ff  <= row_ff;
                        pend_last_ff <= row_last;
                        alu_req_ff   <= '{start: 1'b1, op: ALU_DIV, count: 6'd16,
                                          a: 32'(th), b: {tex_pos_ff[31:16], 16'd0}};
                        state_ff     <= S_TY;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        rsp_kind_ff  <= KIND_LOWER;
                        rsp_row_ff   <= row_ff;
                        rsp_fill_ff  <= lower_fill_ff;
                        rsp_last_ff  <= row_last;
                     end
                  end
               end
            end

            S_PROD: begin
               if (alu_rsp.done) begin
                  if (door_pass) begin
                     pend_kind_ff <= KIND_SKIPPED;
                     state_ff     <= S_OUT;
                  end else begin
                     alu_req_ff <= '{start: 1'b1, op: ALU_MUL, count: 6'(TEX_W),
                                     a: 32'(frac_tex), b: {tw, 19'd0}};
                     state_ff   <= S_TEX;
                  end
               end
            end

            S_TEX: begin
               if (alu_rsp.done) begin
                  tex_col_ff <= mirror_ff ? tx_mirror : tx;
                  if (dist_nonpos) begin
                     lh_ff    <= LH_SAT;
                     state_ff <= S_WALL;
                  end else begin
                     alu_req_ff <= '{start: 1'b1, op: ALU_DIV, count: 6'(LH_W),
                                     a: dist_ff, b: LH_DIVIDEND};
                     state_ff   <= S_HGT;
                  end
               end
            end

            S_HGT: begin
               if (alu_rsp.done) begin
                  lh_ff    <= alu_rsp.quo[LH_W-1:0];
                  state_ff <= S_WALL;
               end
            end

            S_WALL: begin
               wall_top_ff <= wall_top_new;
               wall_bot_ff <= wall_bot_new;
               term_ff     <= top_clamped ? term_diff[LH_W-2:0] : '0;
               if (lh_ff == '0) begin
                  tex_step_ff  <= '0;
                  tex_pos_ff   <= '0;
                  pend_kind_ff <= KIND_READY;
                  state_ff     <= S_OUT;
               end else begin
                  alu_req_ff <= '{start: 1'b1, op: ALU_DIV, count: 6'(TEX_W + 16),
                                  a: 32'(lh_ff), b: {th, 19'd0}};
                  state_ff   <= S_STEP;
               end
            end

            S_STEP: begin
               if (alu_rsp.done) begin
                  tex_step_ff <= alu_rsp.quo;
                  alu_req_ff  <= '{start: 1'b1, op: ALU_MUL, count: 6'(LH_W - 1),
                                   a: alu_rsp.quo, b: 32'(term_ff) << (33 - LH_W)};
                  state_ff    <= S_POS;
               end
            end

            S_POS: begin
               if (alu_rsp.done) begin
                  tex_pos_ff   <= alu_rsp.acc;
                  pend_kind_ff <= KIND_READY;
                  state_ff     <= S_OUT;
               end
            end

            S_TY: begin
               if (alu_rsp.done) begin
                  tex_pos_ff <= tex_pos_ff + tex_step_ff;
                  alu_req_ff <= '{start: 1'b1, op: ALU_MUL, count: 6'd12,
                                  a: 32'(th), b: {alu_rsp.acc[11:0], 20'd0}};
                  state_ff   <= S_TEXEL;
               end
            end

            S_TEXEL: begin
               if (alu_rsp.done) begin
                  pend_texel_ff <= alu_rsp.acc[23:0] + 24'(tex_col_ff);
                  pend_kind_ff  <= KIND_TEXTURED;
                  state_ff      <= S_OUT;
               end
            end

            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_col_ff   <= held_col_ff;
                  rsp_kind_ff  <= pend_kind_ff;
                  rsp_fill_ff  <= '0;
                  if (pend_kind_ff == KIND_TEXTURED) begin
                     rsp_row_ff   <= pend_row_ff;
                     rsp_texel_ff <= pend_texel_ff;
                     rsp_last_ff  <= pend_last_ff;
                  end else begin
                     rsp_row_ff   <= '0;
                     rsp_texel_ff <= '0;
                     rsp_last_ff  <= 1'b0;
                     skipped_ff   <= (pend_kind_ff == KIND_SKIPPED);
                  end
                  state_ff <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_column  = rsp_col_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_pixel_kind  = rsp_kind_ff;
   assign rsp_fill_color  = rsp_fill_ff;
   assign rsp_texel_index = rsp_texel_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- sv/rcct_alu.sv -----
// iterative unit: unsigned multiply (low 32 bits) or divide, one bit a cycle
// depends on rcct_pkg for the request and response structs

module rcct_alu import rcct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   logic        busy_ff;
   logic        done_ff;
   logic        div_ff;
   logic [5:0]  cnt_ff;
   logic [31:0] a_ff;
   logic [31:0] acc_ff;
   logic [31:0] shq_ff;

   logic [31:0] shifted;
   logic [32:0] addend;
   logic [32:0] sum;
   logic        q_bit;
   logic [31:0] acc_in;
   logic [31:0] shq_in;

   // one adder: add the multiplicand or subtract the divisor
   always_comb begin
      shifted = div_ff ? {acc_ff[30:0], shq_ff[31]} : {acc_ff[30:0], 1'b0};
      if (div_ff) begin
         addend = ~{1'b0, a_ff};
      end else begin
         addend = shq_ff[31] ? {1'b0, a_ff} : '0;
      end
      sum    = {1'b0, shifted} + addend + {32'd0, div_ff};
      q_bit  = div_ff & ~sum[32];
      acc_in = (div_ff && sum[32]) ? shifted : sum[31:0];
      shq_in = {shq_ff[30:0], q_bit};
   end

   // sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (alu_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 6'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (alu_req.start) begin
         div_ff <= (alu_req.op == ALU_DIV);
         cnt_ff <= alu_req.count;
         a_ff   <= alu_req.a;
         acc_ff <= '0;
         shq_ff <= alu_req.b;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 6'd1;
         acc_ff <= acc_in;
         shq_ff <= shq_in;
      end
   end

   assign alu_rsp.done = done_ff;
   assign alu_rsp.acc  = acc_ff;
   assign alu_rsp.quo  = shq_ff;

endmodule
